/* design/pbsd_pkg.sv */
// Shared types, codes and helpers for the PackBits scanline decoder.
package pbsd_pkg;

    localparam int LINE_MAX_BYTES_DEF = 16384;
    localparam int LIMIT_W            = 15;
    localparam int BYTE_W             = 8;
    localparam int DATA_W             = 32;
    localparam int COUNT_W            = 3;
    localparam int ERR_W              = 2;
    localparam int S_TDATA_W          = 8;
    localparam int M_TDATA_W          = 40;
    localparam int LANES              = DATA_W / BYTE_W;

    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 15'd16384;
    localparam logic [BYTE_W-1:0]  HDR_NOP          = 8'h80;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_TRUNCATED = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } phase_t;

    typedef struct packed {
        logic                 valid;
        logic [DATA_W-1:0]    data;
        logic [COUNT_W-1:0]   count;
        logic                 last;
        logic                 line_done;
        err_t                 err;
    } result_t;

    // Replicate one byte into the lowest cnt lanes, upper lanes zero.
    function automatic logic [DATA_W-1:0] rep_word(input logic [BYTE_W-1:0] b,
                                                   input logic [COUNT_W-1:0] cnt);
        logic [DATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < LANES; i++) begin
            if (COUNT_W'(i) < cnt) begin
                w[i*BYTE_W +: BYTE_W] = b;
            end
        end
        return w;
    endfunction

endpackage

/* design/packbits_scanline_decoder_top.sv */
// PackBits scanline decoder: compressed byte stream in, packed decoded bytes out.
//
// Input channel (s_*): one compressed byte per beat in s_tdata, s_tlast on the
// last compressed byte of a scanline. Output channel (m_*): up to four decoded
// bytes per beat, byte count and per-input last flag in m_tdata, error code in
// m_tuser, m_tlast on the beat that closes the scanline.
// cfg_wr_en/cfg_wr_data load the per-line byte limit; write only while idle.
// The first result beat of an accepted beat is registered and shows in the next cycle.
// Headers and literal bytes do not hold the input. A repeat value of length n
// occupies ceil(n/4) output beats (up to 32); s_tready stays low after the value
// is accepted until the last of those beats is loaded into the output register.
// A single output register decouples the sides: a new input beat is taken in
// the same cycle the held result is taken. When m_tready is low the result
// holds and s_tready drops.
// Reset (aresetn low, synchronous) clears the line state, empties the output
// register and sets the line limit to 16384.
module packbits_scanline_decoder_top #(
    parameter int LINE_MAX_BYTES = pbsd_pkg::LINE_MAX_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pbsd_pkg::LIMIT_W-1:0]     cfg_wr_data,   // line_limit
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pbsd_pkg::S_TDATA_W-1:0]   s_tdata,       // [7:0] in_byte
    input  logic                             s_tlast,       // end_of_line
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pbsd_pkg::M_TDATA_W-1:0]   m_tdata,       // [31:0] out_data,
                                                            // [34:32] out_count,
                                                            // [35] last, [39:36] 0
    output logic                             m_tlast,       // line_done
    output logic [pbsd_pkg::ERR_W-1:0]       m_tuser        // [1:0] error_code
);

    localparam int CAP   = (LINE_MAX_BYTES < 32767) ? LINE_MAX_BYTES : 32767;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam logic [pbsd_pkg::LIMIT_W-1:0] LIMIT_CAP = pbsd_pkg::LIMIT_W'(CAP);

    logic [pbsd_pkg::LIMIT_W-1:0] line_limit_reg;
    pbsd_pkg::phase_t             phase_reg, phase_next;
    logic [6:0]                   literal_left_reg, literal_left_next;
    logic [7:0]                   repeat_length_reg, repeat_length_next;
    logic [CNT_W-1:0]             bytes_produced_reg, bytes_produced_next;
    logic                         dropping_reg, dropping_next;
    logic [7:0]                   rep_left_reg, rep_left_next;
    logic [7:0]                   rep_byte_reg, rep_byte_next;
    logic                         rep_eol_reg, rep_eol_next;
    pbsd_pkg::result_t            out_reg, out_next;

    logic                         load;
    logic                         busy;
    logic                         s_fire;
    logic [7:0]                   b;
    logic                         eol;
    logic [7:0]                   run_len;
    logic [15:0]                  run_sum;
    logic [pbsd_pkg::LIMIT_W-1:0] eff_limit;
    logic [7:0]                   rep_src;
    logic [2:0]                   rep_cnt;
    logic [7:0]                   rep_rem;
    pbsd_pkg::result_t            first;

    assign busy     = (rep_left_reg != 8'd0);
    assign load     = !out_reg.valid || m_tready;
    assign s_tready = load && !busy;
    assign s_fire   = s_tvalid && s_tready;
    assign b        = s_tdata[7:0];
    assign eol      = s_tlast;

    assign eff_limit = (line_limit_reg > LIMIT_CAP) ? LIMIT_CAP : line_limit_reg;
    assign run_len   = b[7] ? 8'(9'd257 - {1'b0, b}) : (8'(b[6:0]) + 8'd1);
    assign run_sum   = 16'(bytes_produced_reg) + 16'(run_len);

    // Repeat chunk: from the stored length on a new value, else the remainder.
    assign rep_src = busy ? rep_left_reg : repeat_length_reg;
    assign rep_cnt = (rep_src > 8'd4) ? 3'd4 : rep_src[2:0];
    assign rep_rem = rep_src - 8'(rep_cnt);

    always_comb begin
        first               = '0;
        first.err           = pbsd_pkg::ERR_NONE;
        phase_next          = phase_reg;
        literal_left_next   = literal_left_reg;
        repeat_length_next  = repeat_length_reg;
        bytes_produced_next = bytes_produced_reg;
        dropping_next       = dropping_reg;
        rep_left_next       = 8'd0;
        rep_byte_next       = b;
        rep_eol_next        = eol;

        if (dropping_reg) begin
            first.valid     = eol;
            first.last      = 1'b1;
            first.line_done = eol;
            first.err       = pbsd_pkg::ERR_OVERFLOW;
        end else begin
            case (phase_reg)
                pbsd_pkg::PH_LITERAL: begin
                    first.valid     = 1'b1;
                    first.data      = 32'(b);
                    first.count     = 3'd1;
                    first.last      = 1'b1;
                    first.line_done = eol;
                    if (eol && literal_left_reg != 7'd0) begin
                        first.err = pbsd_pkg::ERR_TRUNCATED;
                    end
                    if (literal_left_reg == 7'd0) begin
                        phase_next = pbsd_pkg::PH_HEADER;
                    end else begin
                        literal_left_next = literal_left_reg - 7'd1;
                    end
                end
                pbsd_pkg::PH_REPEAT: begin
                    first.valid        = 1'b1;
                    first.data         = pbsd_pkg::rep_word(b, rep_cnt);
                    first.count        = rep_cnt;
                    first.last         = (rep_rem == 8'd0);
                    first.line_done    = eol && (rep_rem == 8'd0);
                    rep_left_next      = rep_rem;
                    phase_next         = pbsd_pkg::PH_HEADER;
                    repeat_length_next = 8'd0;
                end
                default: begin
                    if (b == pbsd_pkg::HDR_NOP) begin
                        first.valid     = eol;
                        first.last      = 1'b1;
                        first.line_done = eol;
                    end else if (run_sum > 16'(eff_limit)) begin
                        dropping_next   = 1'b1;
                        first.valid     = 1'b1;
                        first.last      = 1'b1;
                        first.line_done = eol;
                        first.err       = pbsd_pkg::ERR_OVERFLOW;
                    end else begin
                        bytes_produced_next = run_sum[CNT_W-1:0];
                        first.valid         = eol;
                        first.last          = 1'b1;
                        first.line_done     = eol;
                        first.err           = pbsd_pkg::ERR_TRUNCATED;
                        if (b[7]) begin
                            phase_next         = pbsd_pkg::PH_REPEAT;
                            repeat_length_next = run_len;
                        end else begin
                            phase_next        = pbsd_pkg::PH_LITERAL;
                            literal_left_next = b[6:0];
                        end
                    end
                end
            endcase
        end

        if (eol) begin
            phase_next          = pbsd_pkg::PH_HEADER;
            literal_left_next   = 7'd0;
            repeat_length_next  = 8'd0;
            bytes_produced_next = '0;
            dropping_next       = 1'b0;
        end
    end

    always_comb begin
        out_next = out_reg;
        if (busy && load) begin
            out_next.valid     = 1'b1;
            out_next.data      = pbsd_pkg::rep_word(rep_byte_reg, rep_cnt);
            out_next.count     = rep_cnt;
            out_next.last      = (rep_rem == 8'd0);
            out_next.line_done = rep_eol_reg && (rep_rem == 8'd0);
            out_next.err       = pbsd_pkg::ERR_NONE;
        end else if (s_fire) begin
            out_next = first;
        end else if (m_tready) begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_limit_reg     <= pbsd_pkg::LINE_LIMIT_RESET;
            phase_reg          <= pbsd_pkg::PH_HEADER;
            literal_left_reg   <= 7'd0;
            repeat_length_reg  <= 8'd0;
            bytes_produced_reg <= '0;
            dropping_reg       <= 1'b0;
            rep_left_reg       <= 8'd0;
            out_reg            <= '0;
        end else begin
            if (cfg_wr_en) begin
                line_limit_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                phase_reg          <= phase_next;
                literal_left_reg   <= literal_left_next;
                repeat_length_reg  <= repeat_length_next;
                bytes_produced_reg <= bytes_produced_next;
                dropping_reg       <= dropping_next;
                rep_left_reg       <= rep_left_next;
            end else if (busy && load) begin
                rep_left_reg <= rep_rem;
            end
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rep_byte_reg <= rep_byte_next;
            rep_eol_reg  <= rep_eol_next;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {4'b0, out_reg.last, out_reg.count, out_reg.data};
    assign m_tlast  = out_reg.line_done;
    assign m_tuser  = out_reg.err;

endmodule

/* design/pbsd_checker.sv */
// Port-level checker for the PackBits scanline decoder, bound to the top level.
module pbsd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pbsd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic [pbsd_pkg::ERR_W-1:0]     m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:32] <= 3'd4)
        else $error("byte count above four");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[34:32] == 3'd0 || m_tuser != pbsd_pkg::ERR_NONE || m_tlast)
            |-> m_tdata[35])
        else $error("status or line end beat not final for its input");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result register full and stalled");

endmodule

bind packbits_scanline_decoder_top pbsd_checker u_pbsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// Testbench for the PackBits scanline decoder: directed table, random lines, beat predictor.
module tb;
    import pbsd_pkg::*;

    localparam int LINE_MAX = LINE_MAX_BYTES_DEF;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               line_done;
        err_t               err;
    } beat_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [LIMIT_W-1:0] val;
        logic               eol;
        logic               typed;
        logic [1:0]         nexp;
        beat_t              exp;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [ERR_W-1:0]     m_tuser;

    // decoder shadow state
    phase_t dec_phase  = PH_HEADER;
    int     lit_left   = 0;
    int     rep_len    = 0;
    int     line_bytes = 0;
    bit     drop_line  = 1'b0;
    int     limit_reg  = int'(LINE_LIMIT_RESET);

    beat_t    step_out[$];
    beat_t    expected_beats[$];
    int       mismatches = 0;
    int       live_items = 0;
    bit       no_gaps    = 1'b0;
    int       stall_left = 0;
    dir_row_t dir_tab[26];

    packbits_scanline_decoder_top #(.LINE_MAX_BYTES(LINE_MAX)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void clear_line();
        dec_phase  = PH_HEADER;
        lit_left   = 0;
        rep_len    = 0;
        line_bytes = 0;
        drop_line  = 1'b0;
    endfunction

    // Work out the beats one compressed byte produces; leaves them in step_out.
    function automatic void decode_byte(input logic [7:0] b, input logic eol);
        int                run_len;
        int                left;
        int                c;
        int                lim;
        int                idx;
        bit                ovf;
        logic [DATA_W-1:0] w;
        err_t              e;
        beat_t             r;
        step_out.delete();
        ovf = 1'b0;
        lim = (limit_reg < LINE_MAX) ? limit_reg : LINE_MAX;
        if (drop_line) begin
        end else if (dec_phase == PH_LITERAL) begin
            step_out.push_back('{DATA_W'(b), 3'd1, 1'b0, 1'b0, ERR_NONE});
            if (lit_left == 0) dec_phase = PH_HEADER;
            else lit_left--;
        end else if (dec_phase == PH_REPEAT) begin
            left = rep_len;
            while (left > 0) begin
                c = (left > LANES) ? LANES : left;
                w = '0;
                for (int i = 0; i < c; i++) w[i*BYTE_W +: BYTE_W] = b;
                step_out.push_back('{w, COUNT_W'(c), 1'b0, 1'b0, ERR_NONE});
                left -= c;
            end
            dec_phase = PH_HEADER;
            rep_len   = 0;
        end else if (b != HDR_NOP) begin
            run_len = (b < 8'h80) ? int'(b) + 1 : 257 - int'(b);
            if (line_bytes + run_len > lim) begin
                drop_line = 1'b1;
                ovf       = 1'b1;
                step_out.push_back('{'0, 3'd0, 1'b0, 1'b0, ERR_OVERFLOW});
            end else begin
                line_bytes += run_len;
                if (b < 8'h80) begin
                    dec_phase = PH_LITERAL;
                    lit_left  = int'(b);
                end else begin
                    dec_phase = PH_REPEAT;
                    rep_len   = run_len;
                end
            end
        end
        if (eol) begin
            if (drop_line) e = ERR_OVERFLOW;
            else if (dec_phase != PH_HEADER) e = ERR_TRUNCATED;
            else e = ERR_NONE;
            if (step_out.size() == 0) begin
                step_out.push_back('{'0, 3'd0, 1'b0, 1'b0, e});
            end
            idx = step_out.size() - 1;
            r = step_out[idx];
            if (!ovf) r.err = e;
            r.line_done = 1'b1;
            step_out[idx] = r;
            clear_line();
        end
        if (step_out.size() > 0) begin
            idx = step_out.size() - 1;
            r = step_out[idx];
            r.last = 1'b1;
            step_out[idx] = r;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eol, input bit use_model);
        int gap;
        gap = (!no_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        live_items++;
        decode_byte(b, eol);
        if (use_model) begin
            foreach (step_out[k]) expected_beats.push_back(step_out[k]);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_reg = int'(v);
    endtask

    task automatic random_line();
        logic [7:0] bytes_q[$];
        int         runs;
        int         len;
        int         r;
        int         cut;
        runs = $urandom_range(1, 4);
        for (int k = 0; k < runs; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128)
                                                   : $urandom_range(1, 6);
                bytes_q.push_back(8'(len - 1));
                repeat (len) bytes_q.push_back(8'($urandom));
            end else if (r < 85) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 128)
                                                  : $urandom_range(2, 12);
                bytes_q.push_back(8'(257 - len));
                bytes_q.push_back(8'($urandom));
            end else if (r < 92) begin
                bytes_q.push_back(HDR_NOP);
            end else begin
                bytes_q.push_back(8'($urandom));
            end
        end
        // truncated line
        if ($urandom_range(0, 6) == 0 && bytes_q.size() > 1) begin
            cut = $urandom_range(1, bytes_q.size() - 1);
            repeat (cut) void'(bytes_q.pop_back());
        end
        no_gaps = ($urandom_range(0, 4) == 0);
        foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b1);
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tdata[34:32], m_tdata[35], m_tlast, err_t'(m_tuser)};
            if (expected_beats.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected beat: data=%h cnt=%0d last=%b eol=%b err=%0d",
                             got.data, got.count, got.last, got.line_done, got.err);
                end
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (got !== want || m_tdata[39:36] !== 4'b0) begin
                    if (mismatches < 10) begin
                        $display("beat mismatch: exp data=%h cnt=%0d last=%b eol=%b err=%0d",
                                 want.data, want.count, want.last, want.line_done, want.err);
                        $display("               got data=%h cnt=%0d last=%b eol=%b err=%0d pad=%h",
                                 got.data, got.count, got.last, got.line_done, got.err,
                                 m_tdata[39:36]);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int phase_limit[5];
        dir_tab = '{
            '{ROW_BEAT, 15'h00, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'hFF, 1'b0, 1'b1, 2'd1, '{32'hFF, 3'd1, 1'b1, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'hFF, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'hA5, 1'b1, 1'b1, 2'd1, '{32'hA5A5, 3'd2, 1'b1, 1'b1, ERR_NONE}},
            '{ROW_BEAT, 15'h80, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h80, 1'b1, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b1, ERR_NONE}},
            '{ROW_BEAT, 15'h81, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h00, 1'b0, 1'b0, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h7F, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h00, 1'b0, 1'b1, 2'd1, '{32'h0, 3'd1, 1'b1, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'hFF, 1'b1, 1'b1, 2'd1, '{32'hFF, 3'd1, 1'b1, 1'b1, ERR_TRUNCATED}},
            '{ROW_BEAT, 15'h05, 1'b1, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b1, ERR_TRUNCATED}},
            '{ROW_BEAT, 15'hFE, 1'b1, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b1, ERR_TRUNCATED}},
            '{ROW_CFG,  15'd4,  1'b0, 1'b0, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h04, 1'b0, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b0, ERR_OVERFLOW}},
            '{ROW_BEAT, 15'h12, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h34, 1'b1, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b1, ERR_OVERFLOW}},
            '{ROW_BEAT, 15'hFD, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h5A, 1'b0, 1'b1, 2'd1, '{32'h5A5A5A5A, 3'd4, 1'b1, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h00, 1'b1, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b1, ERR_OVERFLOW}},
            '{ROW_CFG,  15'd0,  1'b0, 1'b0, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h00, 1'b0, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b0, ERR_OVERFLOW}},
            '{ROW_BEAT, 15'h80, 1'b1, 1'b1, 2'd1, '{32'h0, 3'd0, 1'b1, 1'b1, ERR_OVERFLOW}},
            '{ROW_CFG,  15'h7FFF, 1'b0, 1'b0, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'h81, 1'b0, 1'b1, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}},
            '{ROW_BEAT, 15'hC3, 1'b1, 1'b0, 2'd0, '{32'h0, 3'd0, 1'b0, 1'b0, ERR_NONE}}
        };
        phase_limit = '{32767, $urandom_range(1, 48), 1, $urandom_range(100, 2000), 16384};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_limit(dir_tab[i].val);
            end else begin
                send_byte(dir_tab[i].val[7:0], dir_tab[i].eol, !dir_tab[i].typed);
                if (dir_tab[i].typed && dir_tab[i].nexp != 0) begin
                    expected_beats.push_back(dir_tab[i].exp);
                end
            end
        end

        foreach (phase_limit[p]) begin
            write_limit(LIMIT_W'(phase_limit[p]));
            live_items = 0;
            while (live_items < 48) random_line();
        end

        no_gaps = 1'b0;
        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
